### hw/rtl/stsa_pkg.sv
package stsa_pkg;

   localparam int VALUE_W   = 30;
   localparam int SHUTTER_W = 19;
   localparam int SCREEN_W  = 20;
   localparam int DEVICE_W  = 30;
   localparam int INCR_W    = 25;
   localparam int STEP_W    = 8;
   localparam int SUM_W     = 34;
   localparam int RANGES    = 10;
   localparam int RANGE_IDX_W = $clog2(RANGES);

   typedef enum logic [1:0] {
      KIND_SHUTTER = 2'd0,
      KIND_SCREEN  = 2'd1,
      KIND_DEVICE  = 2'd2
   } kind_type;

   typedef struct packed {
      logic shutter_we;
      logic screen_we;
      logic device_we;
   } update_type;

   localparam logic [VALUE_W-1:0] RANGE_BOUND [RANGES-1] = '{
      30'd20, 30'd150, 30'd500, 30'd1000, 30'd10000, 30'd60000,
      30'd1800000, 30'd7200000, 30'd86400000
   };

   localparam logic [INCR_W-1:0] RANGE_INCR [RANGES] = '{
      25'd1, 25'd5, 25'd10, 25'd100, 25'd1000, 25'd5000,
      25'd60000, 25'd300000, 25'd3600000, 25'd21600000
   };

   localparam logic signed [SUM_W-1:0] SUM_ZERO    = 34'sd0;
   localparam logic signed [SUM_W-1:0] SUM_ONE     = 34'sd1;
   localparam logic signed [SUM_W-1:0] WRAP_LIMIT  = 34'sd2147483648;
   localparam logic signed [SUM_W-1:0] SHUTTER_MAX = 34'sd300000;
   localparam logic signed [SUM_W-1:0] SCREEN_MIN  = 34'sd10000;
   localparam logic signed [SUM_W-1:0] SCREEN_MAX  = 34'sd600000;
   localparam logic signed [SUM_W-1:0] DEVICE_MIN  = 34'sd60000;
   localparam logic signed [SUM_W-1:0] DEVICE_LIMIT = 34'sd1209600000;
   localparam logic signed [SUM_W-1:0] DEVICE_MAX  = 34'sd604800000;

   localparam logic [SHUTTER_W-1:0] SHUTTER_RESET = 19'd1;
   localparam logic [SCREEN_W-1:0]  SCREEN_RESET  = 20'd60000;
   localparam logic [DEVICE_W-1:0]  DEVICE_RESET  = 30'd1800000;

   // upward moves use strict bounds, downward moves inclusive bounds
   function automatic logic [INCR_W-1:0] range_incr(input logic [VALUE_W-1:0] v,
                                                   input logic up);
      logic [RANGE_IDX_W-1:0] idx;
      logic hit;
      idx = RANGE_IDX_W'(RANGES - 1);
      for (int i = RANGES - 2; i >= 0; i--) begin
         hit = up ? (v < RANGE_BOUND[i]) : (v <= RANGE_BOUND[i]);
         if (hit) begin
            idx = RANGE_IDX_W'(i);
         end
      end
      return RANGE_INCR[idx];
   endfunction

endpackage

### hw/rtl/stepped_time_setting_adjust_core.sv
// Keeps the shutter, screen-off and device-off times in milliseconds (reset to 1, 60000 and
// 1800000) and moves the one named by each item by its signed encoder step count, with an
// increment that grows with the present value, then clamps it to that setting's range and
// returns the new value. One item is taken every cycle while the output is not stalled; an
// accepted item is held in the input register, the range select, the 25 by 8 bit step
// multiply and the clamp run combinationally on it, and the result register feeds the output.
// The setting is written at the same edge as the result, so the next item already sees it.
// An unused kind returns 0 and changes nothing. A stalled output holds the result and the
// item behind it.
module stepped_time_setting_adjust_core import stsa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // kind [1:0], step_count [9:2], zero [15:10]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // new_value_ms [29:0], zero [31:30]
);

   logic                     in_valid_ff, in_valid_in;
   kind_type                 kind_ff, kind_in;
   logic signed [STEP_W-1:0] step_ff, step_in;
   logic                     out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0]       out_value_ff, out_value_in;
   logic [SHUTTER_W-1:0]     shutter_ff, shutter_in;
   logic [SCREEN_W-1:0]      screen_ff, screen_in;
   logic [DEVICE_W-1:0]      device_ff, device_in;

   logic                     advance;
   logic                     fire;
   logic [VALUE_W-1:0]       new_value;
   update_type               update;

   stsa_adjust u_adjust (
      .kind          (kind_ff),
      .step_count    (step_ff),
      .shutter_ms    (shutter_ff),
      .screen_off_ms (screen_ff),
      .device_off_ms (device_ff),
      .new_value_ms  (new_value),
      .update        (update)
   );

   always_comb begin
      advance      = !out_valid_ff || rsp_tready;
      fire         = in_valid_ff && advance;
      req_tready   = !in_valid_ff || advance;

      in_valid_in  = in_valid_ff;
      kind_in      = kind_ff;
      step_in      = step_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         kind_in     = kind_type'(req_tdata[1:0]);
         step_in     = $signed(req_tdata[9:2]);
      end

      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
         out_value_in = new_value;
      end

      shutter_in = shutter_ff;
      screen_in  = screen_ff;
      device_in  = device_ff;
      if (fire && update.shutter_we) begin
         shutter_in = new_value[SHUTTER_W-1:0];
      end
      if (fire && update.screen_we) begin
         screen_in = new_value[SCREEN_W-1:0];
      end
      if (fire && update.device_we) begin
         device_in = new_value[DEVICE_W-1:0];
      end

      rsp_tvalid = out_valid_ff;
      rsp_tdata  = {2'b00, out_value_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         shutter_ff   <= SHUTTER_RESET;
         screen_ff    <= SCREEN_RESET;
         device_ff    <= DEVICE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         shutter_ff   <= shutter_in;
         screen_ff    <= screen_in;
         device_ff    <= device_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      step_ff      <= step_in;
      out_value_ff <= out_value_in;
   end

   a_shutter_range: assert property (@(posedge clock) disable iff (reset)
      shutter_ff >= 19'd1 && shutter_ff <= 19'd300000)
      else $error("shutter time out of range");

   a_screen_range: assert property (@(posedge clock) disable iff (reset)
      screen_ff == '0 || (screen_ff >= 20'd10000 && screen_ff <= 20'd600000))
      else $error("screen-off time out of range");

   a_device_range: assert property (@(posedge clock) disable iff (reset)
      device_ff == '0 || (device_ff >= 30'd60000 && device_ff <= 30'd604800000))
      else $error("device-off time out of range");

   a_item_moves_on: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_valid_ff) |=> out_valid_ff)
      else $error("registered item did not reach the output");

endmodule

### hw/rtl/stsa_adjust.sv
module stsa_adjust import stsa_pkg::*; (
   input  kind_type                   kind,
   input  logic signed [STEP_W-1:0]   step_count,
   input  logic [SHUTTER_W-1:0]       shutter_ms,
   input  logic [SCREEN_W-1:0]        screen_off_ms,
   input  logic [DEVICE_W-1:0]        device_off_ms,
   output logic [VALUE_W-1:0]         new_value_ms,
   output update_type                 update
);

   logic [VALUE_W-1:0]      cur;
   logic [INCR_W-1:0]       incr;
   logic signed [INCR_W:0]  incr_s;
   logic signed [SUM_W-1:0] prod;
   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-1:0] v;
   logic                    neg;
   logic                    pos;

   always_comb begin
      neg = step_count[STEP_W-1];
      pos = !neg && (step_count != '0);
      case (kind)
         KIND_SHUTTER: cur = VALUE_W'(shutter_ms);
         KIND_SCREEN:  cur = VALUE_W'(screen_off_ms);
         KIND_DEVICE:  cur = VALUE_W'(device_off_ms);
         default:      cur = '0;
      endcase
      incr   = range_incr(cur, pos);
      incr_s = $signed({1'b0, incr});
      prod   = incr_s * step_count;
      sum    = $signed({{(SUM_W-VALUE_W){1'b0}}, cur}) + prod;

      v      = SUM_ZERO;
      update = '0;
      case (kind)
         KIND_SHUTTER: begin
            if (sum <= SUM_ZERO || sum > WRAP_LIMIT) begin
               v = SUM_ONE;
            end else if (sum > SHUTTER_MAX) begin
               v = SHUTTER_MAX;
            end else begin
               v = sum;
            end
            update.shutter_we = 1'b1;
         end
         KIND_SCREEN: begin
            if (cur == '0 && neg) begin
               v = SUM_ZERO;
            end else begin
               if (sum < SCREEN_MIN) begin
                  v = pos ? SCREEN_MIN : SUM_ZERO;
               end else if (sum > SCREEN_MAX) begin
                  v = SCREEN_MAX;
               end else begin
                  v = sum;
               end
               update.screen_we = 1'b1;
            end
         end
         KIND_DEVICE: begin
            if (cur == '0 && neg) begin
               v = SUM_ZERO;
            end else begin
               if (sum < DEVICE_MIN) begin
                  v = pos ? DEVICE_MIN : SUM_ZERO;
               end else if (sum > DEVICE_LIMIT) begin
                  v = SUM_ZERO;
               end else if (sum > DEVICE_MAX) begin
                  v = DEVICE_MAX;
               end else begin
                  v = sum;
               end
               update.device_we = 1'b1;
            end
         end
         default: begin
            v = SUM_ZERO;
         end
      endcase
      new_value_ms = v[VALUE_W-1:0];
   end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
module testbench import stsa_pkg::*; ();

   localparam int     CYCLE_LIMIT  = 200000;
   localparam int     SETTLE_CYCLES = 8;
   localparam int     REPORT_LINES = 40;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam longint STEP_BOUND [9] = '{
      20, 150, 500, 1000, 10000, 60000, 1800000, 7200000, 86400000
   };
   localparam longint STEP_SIZE [10] = '{
      1, 5, 10, 100, 1000, 5000, 60000, 300000, 3600000, 21600000
   };
   localparam longint WRAP_MS          = 64'sd2147483648;
   localparam longint SHUTTER_CAP_MS   = 300000;
   localparam longint SCREEN_LOW_MS    = 10000;
   localparam longint SCREEN_CAP_MS    = 600000;
   localparam longint DEVICE_LOW_MS    = 60000;
   localparam longint DEVICE_CUTOFF_MS = 1209600000;
   localparam longint DEVICE_CAP_MS    = 604800000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // kind [1:0], step_count [9:2], zero [15:10]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // new_value_ms [29:0], zero [31:30]

   logic [SHUTTER_W-1:0] shutter_now;
   logic [SCREEN_W-1:0]  screen_now;
   logic [DEVICE_W-1:0]  device_now;
   logic [VALUE_W-1:0]   pending_values [$];
   int                   send_idle_pct = 0;
   int                   recv_stall_pct = 0;
   int                   error_count = 0;
   int                   cycle_count = 0;

   stepped_time_setting_adjust_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (error_count < REPORT_LINES) begin
         $display("tb: mismatch (%s) got %0d expected %0d at cycle %0d",
                  what, got, want, cycle_count);
      end
      error_count++;
   endtask

   always @(posedge clock) begin : check_result
      logic [VALUE_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_values.size() == 0) begin
            report_mismatch("unexpected item", rsp_tdata[VALUE_W-1:0], 0);
         end else begin
            want = pending_values.pop_front();
            if (rsp_tdata[VALUE_W-1:0] !== want) begin
               report_mismatch("new_value_ms", rsp_tdata[VALUE_W-1:0], want);
            end
         end
      end
   end

   // increment depends on the range the present value sits in
   function automatic longint stepped_sum(input longint value, input int steps);
      int idx;
      idx = 0;
      if (steps == 0) begin
         return value;
      end
      while (idx < 9 && ((steps > 0) ? (value >= STEP_BOUND[idx]) : (value > STEP_BOUND[idx])))
         idx++;
      return value + STEP_SIZE[idx] * steps;
   endfunction

   function automatic logic [VALUE_W-1:0] next_setting(input logic [1:0] kind,
                                                       input logic signed [7:0] step);
      longint sum;
      int     steps;
      steps = int'(step);
      case (kind)
         KIND_SHUTTER: begin
            sum = stepped_sum(longint'(shutter_now), steps);
            if (sum <= 0 || sum > WRAP_MS) sum = 1;
            if (sum > SHUTTER_CAP_MS) sum = SHUTTER_CAP_MS;
            shutter_now = SHUTTER_W'(sum);
            return VALUE_W'(sum);
         end
         KIND_SCREEN: begin
            if (screen_now == 0 && steps < 0) begin
               return VALUE_W'(screen_now);
            end
            sum = stepped_sum(longint'(screen_now), steps);
            if (sum < SCREEN_LOW_MS) sum = (steps > 0) ? SCREEN_LOW_MS : 0;
            if (sum > SCREEN_CAP_MS) sum = SCREEN_CAP_MS;
            screen_now = SCREEN_W'(sum);
            return VALUE_W'(sum);
         end
         KIND_DEVICE: begin
            if (device_now == 0 && steps < 0) begin
               return VALUE_W'(device_now);
            end
            sum = stepped_sum(longint'(device_now), steps);
            if (sum < DEVICE_LOW_MS) sum = (steps > 0) ? DEVICE_LOW_MS : 0;
            if (sum > DEVICE_CUTOFF_MS) sum = 0;
            if (sum > DEVICE_CAP_MS) sum = DEVICE_CAP_MS;
            device_now = DEVICE_W'(sum);
            return VALUE_W'(sum);
         end
         default: begin
            return '0;
         end
      endcase
   endfunction

   task automatic send_item(input logic [1:0] kind, input logic signed [7:0] step);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, step, kind};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_values.push_back(next_setting(kind, step));
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (pending_values.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // zero steps read back the reset values; the unused kind reads 0
   task automatic test_reset_values();
      send_item(KIND_SHUTTER, 8'sd0);
      send_item(KIND_SCREEN, 8'sd0);
      send_item(KIND_DEVICE, 8'sd0);
      send_item(KIND_UNUSED, 8'sd0);
   endtask

   task automatic test_shutter_limits();
      send_item(KIND_SHUTTER, -8'sd128);
      send_item(KIND_SHUTTER, 8'sd127);
      send_item(KIND_SHUTTER, 8'sd127);
      send_item(KIND_SHUTTER, 8'sd127);
      send_item(KIND_SHUTTER, 8'sd127);
      send_item(KIND_SHUTTER, -8'sd1);
   endtask

   // screen off parks at zero and comes back at the minimum
   task automatic test_screen_limits();
      send_item(KIND_SCREEN, -8'sd128);
      send_item(KIND_SCREEN, -8'sd1);
      send_item(KIND_SCREEN, 8'sd1);
      send_item(KIND_SCREEN, 8'sd127);
      send_item(KIND_SCREEN, -8'sd128);
   endtask

   // past fourteen days the device-off time drops to zero
   task automatic test_device_limits();
      send_item(KIND_DEVICE, 8'sd127);
      send_item(KIND_DEVICE, 8'sd127);
      send_item(KIND_DEVICE, 8'sd6);
      send_item(KIND_DEVICE, 8'sd127);
      send_item(KIND_DEVICE, -8'sd5);
      send_item(KIND_DEVICE, 8'sd1);
      send_item(KIND_DEVICE, -8'sd1);
   endtask

   task automatic test_unused_kind();
      send_item(KIND_UNUSED, -8'sd128);
      send_item(KIND_UNUSED, 8'sd127);
   endtask

   // mostly small steps so the values wander through every range
   task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
      logic [1:0]        kind;
      logic signed [7:0] step;
      int                pick;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         kind = (pick < 6) ? KIND_UNUSED : 2'($urandom_range(2));
         pick = $urandom_range(99);
         if (pick < 10) begin
            step = 8'sd0;
         end else if (pick < 65) begin
            step = 8'($urandom_range(3, 1));
         end else if (pick < 85) begin
            step = 8'($urandom_range(20, 4));
         end else begin
            step = 8'($urandom);
         end
         if (pick < 85 && $urandom_range(1) == 1) begin
            step = -step;
         end
         send_item(kind, step);
      end
      wait_for_results();
   endtask

   initial begin
      shutter_now = 19'd1;
      screen_now  = 20'd60000;
      device_now  = 30'd1800000;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_shutter_limits();
      test_screen_limits();
      test_device_limits();
      test_unused_kind();
      wait_for_results();
      test_random_traffic(0, 0, 370);
      test_random_traffic(80, 0, 370);
      test_random_traffic(0, 80, 370);
      test_random_traffic(27, 27, 370);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/stsa_pkg.sv
hw/rtl/stsa_adjust.sv
hw/rtl/stepped_time_setting_adjust_core.sv
bench/testbench.sv
